FILE: src/cma_pkg.sv
// ============================================================================
// cma_pkg
// Shared types and constants for the contiguous memory allocator.
// ============================================================================
`default_nettype none

package cma_pkg;

  localparam int MEM_UNITS_DEF = 256;
  localparam int TAG_W         = 5;
  localparam int TAG_MAX       = 26;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_DEFRAG = 2'd2,
    CMD_CLEAR  = 2'd3
  } cma_cmd_t;

  typedef enum logic [1:0] {
    MODE_NEXT  = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2,
    MODE_NONC  = 2'd3
  } cma_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_FREE,
    ST_DSCAN,
    ST_DSORT,
    ST_DONE
  } cma_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_SORT,
    CELL_CLEAR
  } cma_cell_op_t;

  typedef struct packed {
    cma_cell_op_t op;
    logic         phase;
  } cma_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] owner_id;
    logic [8:0] unit_count;
  } cma_in_t;

  typedef struct packed {
    logic       success;
    logic [7:0] start_unit;
    logic [8:0] free_units;
    logic [8:0] moved_units;
  } cma_out_t;

endpackage

`default_nettype wire

FILE: src/contiguous_memory_allocator_top.sv
// ============================================================================
// contiguous_memory_allocator_top
// Owner-map allocator built as a ring of unit cells plus a sequencer.
// ============================================================================
// Usage: one command beat on in_* (allocate, free owner, defragment, clear)
// gives one result beat on out_* (success, start unit, free units, moved
// units). cfg_we/cfg_wdata set the placement policy; write it while idle.
// The owner map is a ring of MEM_UNITS cells that rotates one unit per cycle
// past the sequencer during the scan, write, free and count passes; per command:
//   allocate   : scan pass then write pass when placed, scan pass alone if no
//                hole fits, no pass if the tag or size is out of range
//   free owner : one pass
//   defragment : count pass, then odd-even exchange pass
//   clear      : no pass; the map is emptied when the command is taken
// The result beat comes in the same cycle that the next command can be taken.
// One command is in flight at a time; in_stall is high while it runs. The
// result sits in an output register, so a new command is taken while the
// previous result is still stalled; its own result then waits until that
// beat is taken. Reset empties the map, sets the free count to MEM_UNITS,
// the pointer and policy to zero.
// ============================================================================
`default_nettype none

module contiguous_memory_allocator_top #(
  parameter int MEM_UNITS = cma_pkg::MEM_UNITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cma_pkg::cma_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cma_pkg::cma_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata
);
  import cma_pkg::*;

  logic [TAG_W-1:0] cell_q [MEM_UNITS];
  logic [TAG_W-1:0] tail;
  cma_ctl_t         cell_ctl;

  cma_ctrl #(.MEM_UNITS(MEM_UNITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (cell_q[0]),
    .tail      (tail),
    .cell_ctl  (cell_ctl)
  );

  for (genvar i = 0; i < MEM_UNITS; i++) begin : g_cell
    logic [TAG_W-1:0] lv, rv;
    // a used tag at the low edge keeps unit 0 from pairing downward
    assign lv = (i == 0) ? TAG_W'(1) : cell_q[(i == 0) ? 0 : i - 1];
    assign rv = (i == MEM_UNITS - 1) ? tail : cell_q[(i == MEM_UNITS - 1) ? i : i + 1];
    cma_cell #(.ODD(1'(i % 2))) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .left_val  (lv),
      .right_val (rv),
      .q         (cell_q[i])
    );
  end

endmodule

`default_nettype wire

FILE: src/cma_cell.sv
// ============================================================================
// cma_cell
// One owner-map unit: holds, clears, rotates toward the head, or takes part in an
// odd-even exchange that pushes free units toward the high end.
// ============================================================================
`default_nettype none

module cma_cell #(
  parameter bit ODD = 1'b0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cma_pkg::cma_ctl_t        ctl,
  input  wire logic [cma_pkg::TAG_W-1:0] left_val,
  input  wire logic [cma_pkg::TAG_W-1:0] right_val,
  output logic      [cma_pkg::TAG_W-1:0] q
);
  import cma_pkg::*;

  logic [TAG_W-1:0] val_r;
  logic [TAG_W-1:0] val_nxt;
  logic             lower;

  assign lower = (ctl.phase == ODD);

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      CELL_HOLD:  val_nxt = val_r;
      CELL_SHIFT: val_nxt = right_val;
      CELL_CLEAR: val_nxt = '0;
      CELL_SORT: begin
        // pair exchanges only a free unit with a used one, so order of tags holds
        if (lower) begin
          if (val_r == '0 && right_val != '0) val_nxt = right_val;
        end else begin
          if (left_val == '0 && val_r != '0) val_nxt = '0;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

`default_nettype wire

FILE: src/cma_ctrl.sv
// ============================================================================
// cma_ctrl
// Command sequencer: watches the head of the cell ring, steers the ring and
// keeps free count, next-fit pointer, policy register and result register.
// ============================================================================
`default_nettype none

module cma_ctrl #(
  parameter int MEM_UNITS = cma_pkg::MEM_UNITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire cma_pkg::cma_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output cma_pkg::cma_out_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_wdata,
  input  wire logic [cma_pkg::TAG_W-1:0] head,
  output logic      [cma_pkg::TAG_W-1:0] tail,
  output cma_pkg::cma_ctl_t              cell_ctl
);
  import cma_pkg::*;

  localparam int AW = $clog2(MEM_UNITS);
  localparam int CW = $clog2(MEM_UNITS + 1);
  localparam int SW = (CW > 9) ? CW : 9;

  cma_state_t       state_r, state_nxt;
  cma_mode_t        mode_r;
  cma_cmd_t         cmd_r;
  logic [TAG_W-1:0] tag_r;
  logic [SW-1:0]    size_r;
  logic [AW-1:0]    addr_r;
  logic [CW-1:0]    free_count_r;
  logic [AW-1:0]    np_r;
  logic             ok_r;
  logic [AW-1:0]    start_r;
  logic [SW-1:0]    moved_r;
  logic [SW-1:0]    left_r;
  logic             out_valid_r;
  cma_out_t         out_data_r;

  // hole tracking during the allocate scan
  logic             in_hole_r, np_act_r;
  logic [AW-1:0]    hole_start_r;
  logic [SW-1:0]    hole_len_r, np_len_r;
  logic             found_a_r, found_b_r, found_r, ff_found_r;
  logic [AW-1:0]    start_a_r, start_b_r, best_start_r, ff_r;
  logic [SW-1:0]    best_len_r;
  logic             seen_zero_r;

  logic             accept, last, free_u, tag_ok, size_ok, tag_hit, wr_hit;
  logic [SW-1:0]    len_now, nplen_now, ev_len, ev_nplen;
  logic [AW-1:0]    start_now, ev_start;
  logic             npa_now, ev_npact, ev, fit_s, fit_n, better;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign last    = (addr_r == AW'(MEM_UNITS - 1));
  assign free_u  = (head == '0);
  assign tag_ok  = (in_data.owner_id != '0) && (in_data.owner_id <= TAG_W'(TAG_MAX));
  assign size_ok = (in_data.unit_count != '0) &&
                   (SW'(in_data.unit_count) <= SW'(MEM_UNITS));
  assign tag_hit = (tag_r != '0) && (tag_r <= TAG_W'(TAG_MAX)) && (head == tag_r);
  assign wr_hit  = (left_r != '0) && ((mode_r == MODE_NONC) ? free_u : (addr_r >= start_r));

  // hole evaluation, closing either at a used unit or at the map end
  always_comb begin
    len_now   = in_hole_r ? hole_len_r + SW'(1) : SW'(1);
    start_now = in_hole_r ? hole_start_r : addr_r;
    npa_now   = free_u && ((addr_r == np_r) || np_act_r);
    nplen_now = np_act_r ? np_len_r + SW'(1) : SW'(1);
    ev        = (in_hole_r && !free_u) || (free_u && last);
    ev_len    = free_u ? len_now : hole_len_r;
    ev_start  = free_u ? start_now : hole_start_r;
    ev_npact  = free_u ? npa_now : np_act_r;
    ev_nplen  = free_u ? nplen_now : np_len_r;
    fit_s     = ev && (ev_len >= size_r);
    fit_n     = ev && ev_npact && (ev_start < np_r) && (ev_nplen >= size_r);
    better    = !found_r || ((mode_r == MODE_BEST) && (ev_len < best_len_r)) ||
                ((mode_r == MODE_WORST) && (ev_len > best_len_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cma_cmd_t'(in_data.cmd))
            CMD_ALLOC:  state_nxt = (tag_ok && size_ok) ? ST_SCAN : ST_DONE;
            CMD_FREE:   state_nxt = ST_FREE;
            CMD_DEFRAG: state_nxt = ST_DSCAN;
            CMD_CLEAR:  state_nxt = ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN:   if (last) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        priority if (mode_r == MODE_NONC)
          state_nxt = (SW'(free_count_r) >= size_r) ? ST_WRITE : ST_DONE;
        else if (mode_r == MODE_NEXT)
          state_nxt = (found_a_r || found_b_r) ? ST_WRITE : ST_DONE;
        else
          state_nxt = found_r ? ST_WRITE : ST_DONE;
      end
      ST_WRITE:  if (last) state_nxt = ST_DONE;
      ST_FREE:   if (last) state_nxt = ST_DONE;
      ST_DSCAN:  if (last) state_nxt = ST_DSORT;
      ST_DSORT:  if (last) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ring control
  always_comb begin
    cell_ctl.op    = CELL_HOLD;
    cell_ctl.phase = addr_r[0];
    tail           = head;
    unique case (state_r)
      ST_SCAN, ST_DSCAN: cell_ctl.op = CELL_SHIFT;
      ST_WRITE: begin
        cell_ctl.op = CELL_SHIFT;
        if (wr_hit) tail = tag_r;
      end
      ST_FREE: begin
        cell_ctl.op = CELL_SHIFT;
        if (tag_hit) tail = '0;
      end
      ST_DSORT: begin
        cell_ctl.op = CELL_SORT;
        tail        = '0;
      end
      ST_IDLE: begin
        if (accept && cma_cmd_t'(in_data.cmd) == CMD_CLEAR) cell_ctl.op = CELL_CLEAR;
      end
      default: cell_ctl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_NEXT;
      free_count_r <= CW'(MEM_UNITS);
      np_r         <= '0;
      addr_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cma_mode_t'(cfg_wdata);
      if (state_r == ST_SCAN || state_r == ST_WRITE || state_r == ST_FREE ||
          state_r == ST_DSCAN || state_r == ST_DSORT) begin
        addr_r <= last ? '0 : addr_r + AW'(1);
      end
      if (accept && cma_cmd_t'(in_data.cmd) == CMD_CLEAR) begin
        free_count_r <= CW'(MEM_UNITS);
        np_r         <= '0;
      end
      if (state_r == ST_FREE && tag_hit) free_count_r <= free_count_r + CW'(1);
      if (state_r == ST_WRITE && last) begin
        free_count_r <= free_count_r - CW'(size_r);
        if (mode_r != MODE_NONC)
          np_r <= ((SW'(start_r) + size_r) == SW'(MEM_UNITS)) ? '0 :
                  AW'(SW'(start_r) + size_r);
      end
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= cma_cmd_t'(in_data.cmd);
      tag_r        <= in_data.owner_id;
      size_r       <= SW'(in_data.unit_count);
      ok_r         <= !(cma_cmd_t'(in_data.cmd) == CMD_ALLOC);
      start_r      <= '0;
      moved_r      <= '0;
      in_hole_r    <= 1'b0;
      np_act_r     <= 1'b0;
      hole_len_r   <= '0;
      np_len_r     <= '0;
      hole_start_r <= '0;
      found_a_r    <= 1'b0;
      found_b_r    <= 1'b0;
      found_r      <= 1'b0;
      ff_found_r   <= 1'b0;
      seen_zero_r  <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      in_hole_r    <= free_u;
      hole_len_r   <= free_u ? len_now : '0;
      hole_start_r <= start_now;
      np_act_r     <= npa_now;
      np_len_r     <= npa_now ? nplen_now : '0;
      if (free_u && !ff_found_r) begin
        ff_found_r <= 1'b1;
        ff_r       <= addr_r;
      end
      if (fit_s) begin
        if (ev_start >= np_r) begin
          if (!found_a_r) begin
            found_a_r <= 1'b1;
            start_a_r <= ev_start;
          end
        end else if (!found_b_r) begin
          found_b_r <= 1'b1;
          start_b_r <= ev_start;
        end
        if (better) begin
          found_r      <= 1'b1;
          best_start_r <= ev_start;
          best_len_r   <= ev_len;
        end
      end
      // the pointer itself opens a candidate inside its hole
      if (fit_n && !found_a_r) begin
        found_a_r <= 1'b1;
        start_a_r <= np_r;
      end
    end
    if (state_r == ST_DECIDE) begin
      left_r <= size_r;
      priority if (mode_r == MODE_NONC) begin
        ok_r    <= (SW'(free_count_r) >= size_r);
        start_r <= (SW'(free_count_r) >= size_r) ? ff_r : '0;
      end else if (mode_r == MODE_NEXT) begin
        ok_r    <= found_a_r || found_b_r;
        start_r <= found_a_r ? start_a_r : (found_b_r ? start_b_r : '0);
      end else begin
        ok_r    <= found_r;
        start_r <= found_r ? best_start_r : '0;
      end
    end
    if (state_r == ST_WRITE && wr_hit) left_r <= left_r - SW'(1);
    if (state_r == ST_DSCAN) begin
      // a used unit behind any free unit belongs to a run that slides down
      if (free_u) seen_zero_r <= 1'b1;
      else if (seen_zero_r) moved_r <= moved_r + SW'(1);
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.success     <= ok_r;
      out_data_r.start_unit  <= 8'(start_r);
      out_data_r.free_units  <= 9'(free_count_r);
      out_data_r.moved_units <= 9'(moved_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(free_count_r) <= SW'(MEM_UNITS))
    else $error("free count above map size");
  a_fail_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.success) |-> (out_data_r.moved_units == '0 &&
     out_data_r.start_unit == '0))
    else $error("failed allocate reports data");
  a_write_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (cmd_r == CMD_ALLOC && ok_r))
    else $error("write pass without placement");

endmodule

`default_nettype wire
